@@ rtl/nfsc_pkg.sv @@
// Shared types and constants for the NOR flash sector controller.
package nfsc_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_WORD,
        ST_DIV,
        ST_ERASE,
        ST_CHK_RD,
        ST_CHK_CMP
    } t_state;

    typedef logic [2:0] t_opcode;

    localparam t_opcode OP_READ  = 3'd0;
    localparam t_opcode OP_PROG  = 3'd1;
    localparam t_opcode OP_ERASE = 3'd2;
    localparam t_opcode OP_CHECK = 3'd3;
    localparam t_opcode OP_FIRST = 3'd4;

    localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;

endpackage

@@ rtl/nor_flash_sector_controller_top.sv @@
// NOR flash sector controller: command port over a word-wide flash array.
//
// A command is taken when start is high and busy is low; opcode, address,
// data and the two protection flags are sampled in that transaction. Each
// command gives one result on o_status and o_value, shown for exactly one
// cycle while o_done is high; the receiver cannot stall, and busy is already
// low in that cycle so the next command may follow at once.
// Read and program pass through the read and word states before o_done.
// Refused commands answer in the cycle after start. Erase and check first
// wait on the remainder unit (multiply by the reciprocal, multiply back and
// subtract) to find the sector start, and a refused first-sector erase
// answers once that is done; erase then writes one word per cycle, check
// reads each word through the memory read port and then compares it, and
// stops at the first programmed word. First-empty walks sectors from the
// second one the same way. The flash_base register is written with
// i_cfg_we / i_cfg_wdata. After reset the array is set to all ones by a
// clearing pass over every word, during which busy is high.
module nor_flash_sector_controller_top #(
    parameter int FLASH_BYTES  = 262144,
    parameter int SECTOR_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_address,
    input  logic [31:0] i_data,
    input  logic        i_allow_first_sector,
    input  logic        i_override_config,
    output logic        o_done,
    output logic        o_status,
    output logic [31:0] o_value
);

    localparam int WORD_COUNT = FLASH_BYTES / 4;
    localparam int AW         = $clog2(WORD_COUNT);
    localparam int OW         = $clog2(FLASH_BYTES);
    localparam int CW         = $clog2(FLASH_BYTES + SECTOR_BYTES + 4);
    localparam int RW         = $clog2(SECTOR_BYTES);

    nfsc_pkg::t_state  r_state, n_state;
    nfsc_pkg::t_opcode r_op, n_op;
    logic [31:0]       r_flash_base;
    logic [31:0]       r_data, n_data;
    logic              r_allow, n_allow;
    logic              r_over, n_over;
    logic [OW-1:0]     r_off, n_off;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_end, n_end;
    logic [CW-1:0]     r_sec, n_sec;
    logic [AW-1:0]     r_clr, n_clr;
    logic              r_done, n_done;
    logic              r_status, n_status;
    logic [31:0]       r_value, n_value;
    logic [31:0]       r_rdata;

    logic [31:0]       mem [WORD_COUNT];
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [31:0]       mem_wdata;
    logic [AW-1:0]     word_idx;
    logic [CW-3:0]     idx_full;

    logic              rem_start;
    logic              rem_done;
    logic [RW-1:0]     rem;

    logic [31:0]       off32;
    logic              in_window;
    logic              aligned;
    logic [CW-1:0]     sec_start;
    logic [CW-1:0]     next_pos;
    logic [CW-1:0]     next_sec;

    function automatic logic [CW-1:0] sec_limit(input logic [CW-1:0] s);
        logic [CW-1:0] sum;
        sum = s + CW'(SECTOR_BYTES);
        return (sum > CW'(FLASH_BYTES)) ? CW'(FLASH_BYTES) : sum;
    endfunction

    nfsc_sector_rem #(
        .DIVISOR (SECTOR_BYTES),
        .DW      (OW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_off),
        .o_done     (rem_done),
        .o_rem      (rem)
    );

    always_comb begin
        idx_full = r_pos[CW-1:2];
        if (idx_full >= (CW-2)'(WORD_COUNT)) begin
            word_idx = AW'(idx_full - (CW-2)'(WORD_COUNT));
        end else begin
            word_idx = AW'(idx_full);
        end
    end

    assign off32     = i_address - r_flash_base;
    assign in_window = off32 < 32'(FLASH_BYTES);
    assign aligned   = off32[1:0] == 2'b00;
    assign sec_start = CW'(r_off) - CW'(rem);
    assign next_pos  = r_pos + CW'(4);
    assign next_sec  = r_sec + CW'(SECTOR_BYTES);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_data    = r_data;
        n_allow   = r_allow;
        n_over    = r_over;
        n_off     = r_off;
        n_pos     = r_pos;
        n_end     = r_end;
        n_sec     = r_sec;
        n_clr     = r_clr;
        n_done    = 1'b0;
        n_status  = r_status;
        n_value   = r_value;
        mem_we    = 1'b0;
        mem_waddr = word_idx;
        mem_wdata = nfsc_pkg::ERASED_WORD;
        rem_start = 1'b0;

        unique case (r_state)
            nfsc_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(WORD_COUNT - 1)) begin
                    n_state = nfsc_pkg::ST_IDLE;
                end
            end
            nfsc_pkg::ST_IDLE: begin
                if (start) begin
                    n_op     = i_opcode;
                    n_data   = i_data;
                    n_allow  = i_allow_first_sector;
                    n_over   = i_override_config;
                    n_off    = off32[OW-1:0];
                    n_pos    = CW'(off32[OW-1:0]);
                    n_status = 1'b1;
                    n_value  = '0;
                    unique case (i_opcode)
                        nfsc_pkg::OP_READ: begin
                            if (in_window && aligned) begin
                                n_state = nfsc_pkg::ST_RD;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        nfsc_pkg::OP_PROG: begin
                            if (in_window && aligned &&
                                !(off32 < 32'(SECTOR_BYTES) && !i_allow_first_sector &&
                                  !i_override_config)) begin
                                n_state = nfsc_pkg::ST_RD;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        nfsc_pkg::OP_ERASE, nfsc_pkg::OP_CHECK: begin
                            if (in_window) begin
                                rem_start = 1'b1;
                                n_state   = nfsc_pkg::ST_DIV;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        nfsc_pkg::OP_FIRST: begin
                            if (SECTOR_BYTES < FLASH_BYTES) begin
                                n_sec   = CW'(SECTOR_BYTES);
                                n_pos   = CW'(SECTOR_BYTES);
                                n_end   = sec_limit(CW'(SECTOR_BYTES));
                                n_state = nfsc_pkg::ST_CHK_RD;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            nfsc_pkg::ST_RD: begin
                n_state = nfsc_pkg::ST_WORD;
            end
            nfsc_pkg::ST_WORD: begin
                n_state = nfsc_pkg::ST_IDLE;
                n_done  = 1'b1;
                if (r_op == nfsc_pkg::OP_READ) begin
                    n_status = 1'b0;
                    n_value  = r_rdata;
                end else if ((r_rdata & r_data) == r_data) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_data;
                    n_status  = 1'b0;
                end
            end
            nfsc_pkg::ST_DIV: begin
                if (rem_done) begin
                    n_pos = sec_start;
                    n_end = sec_limit(sec_start);
                    if (r_op == nfsc_pkg::OP_ERASE) begin
                        if (sec_start < CW'(SECTOR_BYTES) && !r_allow) begin
                            n_state = nfsc_pkg::ST_IDLE;
                            n_done  = 1'b1;
                        end else begin
                            n_state = nfsc_pkg::ST_ERASE;
                        end
                    end else begin
                        n_state = nfsc_pkg::ST_CHK_RD;
                    end
                end
            end
            nfsc_pkg::ST_ERASE: begin
                mem_we = 1'b1;
                n_pos  = next_pos;
                if (next_pos >= r_end) begin
                    n_state  = nfsc_pkg::ST_IDLE;
                    n_done   = 1'b1;
                    n_status = 1'b0;
                end
            end
            nfsc_pkg::ST_CHK_RD: begin
                n_state = nfsc_pkg::ST_CHK_CMP;
            end
            nfsc_pkg::ST_CHK_CMP: begin
                if (r_rdata != nfsc_pkg::ERASED_WORD) begin
                    if (r_op == nfsc_pkg::OP_CHECK || next_sec >= CW'(FLASH_BYTES)) begin
                        n_state = nfsc_pkg::ST_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_sec   = next_sec;
                        n_pos   = next_sec;
                        n_end   = sec_limit(next_sec);
                        n_state = nfsc_pkg::ST_CHK_RD;
                    end
                end else if (next_pos >= r_end) begin
                    n_state  = nfsc_pkg::ST_IDLE;
                    n_done   = 1'b1;
                    n_status = 1'b0;
                    if (r_op == nfsc_pkg::OP_FIRST) begin
                        n_value = r_flash_base + 32'(r_sec);
                    end
                end else begin
                    n_pos   = next_pos;
                    n_state = nfsc_pkg::ST_CHK_RD;
                end
            end
            default: begin
                n_state = nfsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= nfsc_pkg::ST_CLEAR;
            r_clr        <= '0;
            r_done       <= 1'b0;
            r_flash_base <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_flash_base <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_data   <= n_data;
        r_allow  <= n_allow;
        r_over   <= n_over;
        r_off    <= n_off;
        r_pos    <= n_pos;
        r_end    <= n_end;
        r_sec    <= n_sec;
        r_status <= n_status;
        r_value  <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[word_idx];
    end

    assign busy     = r_state != nfsc_pkg::ST_IDLE;
    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_value  = r_value;

endmodule

@@ rtl/nfsc_sector_rem.sv @@
// Remainder of a window offset by the sector size, by reciprocal multiplication.
module nfsc_sector_rem #(
    parameter int DIVISOR = 2048,
    parameter int DW      = 18
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DW-1:0]              i_dividend,
    output logic                       o_done,
    output logic [$clog2(DIVISOR)-1:0] o_rem
);

    localparam int RW = $clog2(DIVISOR);
    localparam int SH = DW + RW;
    localparam int MW = DW + 1;
    localparam int PW = DW + MW;
    localparam logic [63:0] MAGIC64 =
        ((64'd1 << SH) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
    localparam logic [MW-1:0] MAGIC = MW'(MAGIC64);

    logic          r_go;
    logic          r_mul_v;
    logic          r_done;
    logic [DW-1:0] r_dvd;
    logic [PW-1:0] r_prod;
    logic [RW-1:0] r_rem;
    logic [PW-1:0] prod_sh;
    logic [DW-1:0] quo;
    logic [DW-1:0] quo_times_d;

    assign prod_sh     = r_prod >> SH;
    assign quo         = prod_sh[DW-1:0];
    assign quo_times_d = quo * DW'(DIVISOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go    <= 1'b0;
            r_mul_v <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_go    <= i_start;
            r_mul_v <= r_go;
            r_done  <= r_mul_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd  <= i_dividend;
        r_prod <= PW'(i_dividend) * PW'(MAGIC);
        r_rem  <= RW'(r_dvd - quo_times_d);
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ bench/nor_flash_sector_controller_top_tb.sv @@
// Self-checking testbench for the NOR flash sector controller command port.
module nor_flash_sector_controller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FLASH_BYTES   = 262144;
    localparam int SECTOR_BYTES  = 2048;
    localparam int FLASH_WORDS   = FLASH_BYTES / 4;
    localparam int SECTOR_COUNT  = FLASH_BYTES / SECTOR_BYTES;
    localparam int CYCLE_LIMIT   = 40_000_000;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam nfsc_pkg::t_opcode OP_LAST = 3'd7;

    typedef struct {
        nfsc_pkg::t_opcode op;
        logic [31:0]       addr;
        logic [31:0]       data;
        logic              allow;
        logic              over;
    } flash_cmd_t;

    typedef struct {
        nfsc_pkg::t_opcode op;
        logic              status;
        logic [31:0]       value;
    } flash_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_opcode = nfsc_pkg::OP_READ;
    logic [31:0] i_address = '0;
    logic [31:0] i_data = '0;
    logic        i_allow_first_sector = 1'b0;
    logic        i_override_config = 1'b0;
    logic        o_done;
    logic        o_status;
    logic [31:0] o_value;

    logic [31:0]   flash_image [FLASH_WORDS];
    logic [31:0]   window_base = '0;
    flash_result_t expected_results [$];
    flash_result_t head_result;
    int            error_count = 0;
    int            cycle_count = 0;
    bit            gaps_on = 1'b1;

    nor_flash_sector_controller_top #(
        .FLASH_BYTES (FLASH_BYTES),
        .SECTOR_BYTES(SECTOR_BYTES)
    ) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .start               (start),
        .busy                (busy),
        .i_opcode            (i_opcode),
        .i_address           (i_address),
        .i_data              (i_data),
        .i_allow_first_sector(i_allow_first_sector),
        .i_override_config   (i_override_config),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_value             (o_value)
    );

    always #5 i_clk = ~i_clk;

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    function automatic int sector_end_word(input logic [31:0] sec_off);
        if (sec_off + SECTOR_BYTES > FLASH_BYTES) begin
            return FLASH_WORDS;
        end
        return int'((sec_off + SECTOR_BYTES) >> 2);
    endfunction

    function automatic logic sector_is_blank(input logic [31:0] sec_off);
        int last;
        last = sector_end_word(sec_off);
        for (int w = int'(sec_off >> 2); w < last; w++) begin
            if (flash_image[w] !== nfsc_pkg::ERASED_WORD) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic predict_flash(input flash_cmd_t c, output flash_result_t r);
        logic [31:0] off;
        logic [31:0] sec;
        logic        in_win;
        logic        found;
        int          w;
        int          last;
        r.op = c.op;
        r.status = 1'b1;
        r.value = '0;
        off = c.addr - window_base;
        in_win = off < 32'(FLASH_BYTES);
        sec = off - (off % 32'(SECTOR_BYTES));
        w = int'(off >> 2);
        case (c.op)
            nfsc_pkg::OP_READ: begin
                if (in_win && off[1:0] == 2'b00) begin
                    r.value = flash_image[w];
                    r.status = 1'b0;
                end
            end
            nfsc_pkg::OP_PROG: begin
                if (in_win && off[1:0] == 2'b00
                        && !(off < 32'(SECTOR_BYTES) && !c.allow && !c.over)
                        && (flash_image[w] & c.data) == c.data) begin
                    flash_image[w] = c.data;
                    r.status = 1'b0;
                end
            end
            nfsc_pkg::OP_ERASE: begin
                if (in_win && !(sec < 32'(SECTOR_BYTES) && !c.allow)) begin
                    last = sector_end_word(sec);
                    for (int i = int'(sec >> 2); i < last; i++) begin
                        flash_image[i] = nfsc_pkg::ERASED_WORD;
                    end
                    r.status = 1'b0;
                end
            end
            nfsc_pkg::OP_CHECK: begin
                if (in_win && sector_is_blank(sec)) begin
                    r.status = 1'b0;
                end
            end
            nfsc_pkg::OP_FIRST: begin
                found = 1'b0;
                for (sec = 32'(SECTOR_BYTES); sec < 32'(FLASH_BYTES) && !found;
                        sec += 32'(SECTOR_BYTES)) begin
                    if (sector_is_blank(sec)) begin
                        found = 1'b1;
                        r.value = window_base + sec;
                        r.status = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    function automatic flash_cmd_t make_cmd(input nfsc_pkg::t_opcode op,
                                            input logic [31:0] addr,
                                            input logic [31:0] data, input logic allow,
                                            input logic over);
        flash_cmd_t c;
        c.op = op;
        c.addr = addr;
        c.data = data;
        c.allow = allow;
        c.over = over;
        return c;
    endfunction

    task automatic issue_cmd(input flash_cmd_t c);
        flash_result_t r;
        i_opcode <= c.op;
        i_address <= c.addr;
        i_data <= c.data;
        i_allow_first_sector <= c.allow;
        i_override_config <= c.over;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_flash(c, r);
        expected_results.push_back(r);
        if (gaps_on && $urandom_range(0, 99) < 7) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain_pending();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_base(input logic [31:0] base);
        drain_pending();
        i_cfg_wdata <= base;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        window_base = base;
    endtask

    function automatic logic [31:0] pick_address();
        int          r;
        int          sec;
        logic [31:0] off;
        r = $urandom_range(0, 99);
        if (r < 7) begin
            return $urandom();
        end
        if (r < 11) begin
            return window_base + 32'(FLASH_BYTES) + 32'($urandom_range(0, 4095));
        end
        if (r < 14) begin
            return window_base - 32'($urandom_range(1, 4096));
        end
        if ($urandom_range(0, 99) < 80) begin
            sec = $urandom_range(0, 5);
            if (sec > 3) begin
                sec = SECTOR_COUNT - 6 + sec;
            end
        end else begin
            sec = $urandom_range(0, SECTOR_COUNT - 1);
        end
        if ($urandom_range(0, 99) < 70) begin
            off = 32'(sec * SECTOR_BYTES + 4 * $urandom_range(0, 7));
        end else begin
            off = 32'(sec * SECTOR_BYTES + 4 * $urandom_range(0, SECTOR_BYTES / 4 - 1));
        end
        if ($urandom_range(0, 99) < 5) begin
            off += 32'($urandom_range(1, 3));
        end
        return window_base + off;
    endfunction

    task automatic test_directed();
        issue_cmd(make_cmd(nfsc_pkg::OP_READ, 32'h0000_0000, $urandom(), 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_READ, 32'h0003_FFFC, $urandom(), 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_READ, 32'h0004_0000, $urandom(), 1'b1, 1'b1));
        issue_cmd(make_cmd(nfsc_pkg::OP_READ, 32'hFFFF_FFFC, $urandom(), 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_READ, 32'h0000_0802, $urandom(), 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_PROG, 32'h0000_0800, 32'h0000_0000, 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_PROG, 32'h0000_0800, 32'hFFFF_FFFF, 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_PROG, 32'h0000_0804, 32'hFFFF_FFFF, 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_PROG, 32'h0000_0806, 32'h0000_0000, 1'b1, 1'b1));
        issue_cmd(make_cmd(nfsc_pkg::OP_PROG, 32'h0000_0000, 32'h1234_5678, 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_PROG, 32'h0000_0000, 32'h1234_5678, 1'b0, 1'b1));
        issue_cmd(make_cmd(nfsc_pkg::OP_PROG, 32'h0000_0004, 32'hA5A5_A5A5, 1'b1, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_READ, 32'h0000_0004, $urandom(), 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_CHECK, 32'h0000_07FF, $urandom(), 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_ERASE, 32'h0000_0010, $urandom(), 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_ERASE, 32'h0000_0010, $urandom(), 1'b0, 1'b1));
        issue_cmd(make_cmd(nfsc_pkg::OP_ERASE, 32'h0000_0010, $urandom(), 1'b1, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_CHECK, 32'h0000_0000, $urandom(), 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_FIRST, $urandom(), $urandom(), 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_ERASE, 32'h0003_FFFF, $urandom(), 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_ERASE, 32'h0004_0000, $urandom(), 1'b1, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_CHECK, 32'h0004_0000, $urandom(), 1'b0, 1'b0));
        for (int op = nfsc_pkg::OP_FIRST + 1; op <= OP_LAST; op++) begin
            issue_cmd(make_cmd(nfsc_pkg::t_opcode'(op), 32'h0000_0800, $urandom(),
                               1'b1, 1'b1));
        end
        issue_cmd(make_cmd(nfsc_pkg::OP_ERASE, 32'h0000_09AB, $urandom(), 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_FIRST, $urandom(), $urandom(), 1'b1, 1'b1));
    endtask

    task automatic test_first_empty_exhausted();
        for (int s = 1; s < SECTOR_COUNT; s++) begin
            issue_cmd(make_cmd(nfsc_pkg::OP_PROG, window_base + 32'(s * SECTOR_BYTES),
                               32'h0, 1'b0, 1'b0));
        end
        issue_cmd(make_cmd(nfsc_pkg::OP_FIRST, $urandom(), $urandom(), 1'b0, 1'b0));
        for (int s = 1; s < SECTOR_COUNT; s++) begin
            issue_cmd(make_cmd(nfsc_pkg::OP_ERASE, window_base + 32'(s * SECTOR_BYTES),
                               $urandom(), 1'b0, 1'b0));
        end
    endtask

    task automatic test_random_traffic(input int count);
        flash_cmd_t  c;
        int          r;
        logic [31:0] off;
        logic [31:0] recent_prog;
        recent_prog = window_base;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 28) begin
                c.op = nfsc_pkg::OP_READ;
            end else if (r < 60) begin
                c.op = nfsc_pkg::OP_PROG;
            end else if (r < 69) begin
                c.op = nfsc_pkg::OP_ERASE;
            end else if (r < 79) begin
                c.op = nfsc_pkg::OP_CHECK;
            end else if (r < 86) begin
                c.op = nfsc_pkg::OP_FIRST;
            end else if (r < 90) begin
                c.op = nfsc_pkg::t_opcode'($urandom_range(nfsc_pkg::OP_FIRST + 1, OP_LAST));
            end else begin
                c.op = nfsc_pkg::OP_PROG;
            end
            c.addr = pick_address();
            if (c.op == nfsc_pkg::OP_READ && $urandom_range(0, 2) == 0) begin
                c.addr = recent_prog;
            end
            c.allow = ($urandom_range(0, 3) == 0);
            c.over = ($urandom_range(0, 3) == 0);
            c.data = $urandom();
            if (c.op == nfsc_pkg::OP_PROG) begin
                off = c.addr - window_base;
                if (off < 32'(FLASH_BYTES) && off[1:0] == 2'b00) begin
                    r = $urandom_range(0, 99);
                    if (r < 60) begin
                        c.data = flash_image[int'(off >> 2)] & $urandom();
                    end else if (r < 75) begin
                        c.data = flash_image[int'(off >> 2)];
                    end
                end
                recent_prog = c.addr;
            end
            issue_cmd(c);
        end
    endtask

    task automatic test_window_wrap();
        write_window_base(32'hFFFF_F800);
        issue_cmd(make_cmd(nfsc_pkg::OP_READ, 32'hFFFF_F7FC, $urandom(), 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_PROG, 32'h0000_0000, 32'h0F0F_0F0F, 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_READ, 32'h0000_0000, $urandom(), 1'b0, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_ERASE, 32'hFFFF_FFFF, $urandom(), 1'b1, 1'b0));
        issue_cmd(make_cmd(nfsc_pkg::OP_FIRST, $urandom(), $urandom(), 1'b0, 1'b0));
        test_random_traffic(250);
    endtask

    task automatic test_base_extremes();
        write_window_base(32'hFFFF_FFFF);
        test_random_traffic(150);
        write_window_base($urandom());
        test_random_traffic(150);
        write_window_base(32'h0000_0000);
        test_random_traffic(100);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_results.size() == 0) begin
                note_error($sformatf("result with none pending: status %0b value %08h",
                                     o_status, o_value));
            end else begin
                head_result = expected_results.pop_front();
                if (o_status !== head_result.status || o_value !== head_result.value) begin
                    note_error($sformatf(
                        "op %0d mismatch: expected status %0b value %08h, got %0b %08h",
                        head_result.op, head_result.status, head_result.value,
                        o_status, o_value));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("nor_flash_sector_controller_top_tb: done, errors");
            $finish;
        end
    end

    initial begin
        for (int w = 0; w < FLASH_WORDS; w++) begin
            flash_image[w] = nfsc_pkg::ERASED_WORD;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        write_window_base(32'h0000_0000);
        test_directed();
        test_first_empty_exhausted();
        test_random_traffic(200);
        gaps_on = 1'b0;
        test_random_traffic(250);
        gaps_on = 1'b1;
        test_window_wrap();
        test_base_extremes();
        drain_pending();
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("nor_flash_sector_controller_top_tb: done, clean");
        end else begin
            $display("nor_flash_sector_controller_top_tb: done, errors");
        end
        $finish;
    end

endmodule
